// ===== design/evtb_pkg.sv =====
// ----------------------------------------------------------------------------
// evtb_pkg: shared types and constants for the Euler vertex transform
// Fixed-point formats, item structs, divide-by-constant reciprocals and the
// rounding and saturation helpers used by the shared multiplier datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package evtb_pkg;

	localparam int CoordW    = 32;            // signed Q18.14 coordinates
	localparam int TrigW     = 18;            // signed matrix terms
	localparam int TrigFrac  = TrigW - 2;
	localparam int TrigAccW  = TrigW + 2;     // sum of two matrix products
	localparam int ScaleFrac = 12;
	localparam int MulW      = 33;            // shared multiplier operand
	localparam int ProdW     = 2 * MulW;
	localparam int AccW      = CoordW + 6;    // rotated sums and placement

	localparam logic [31:0] PiQ30  = 32'd3373259426;
	localparam logic [30:0] OneQ30 = 31'h4000_0000;
	localparam logic signed [AccW-1:0] MapMid = AccW'(279620267);

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [TrigW-1:0]  trig_t;

	typedef struct packed {
		logic signed [CoordW-1:0] model_x;
		logic signed [CoordW-1:0] model_y;
		logic signed [CoordW-1:0] model_z;
		logic                     restart_box;
	} vertex_t;

	typedef struct packed {
		logic signed [CoordW-1:0] world_x;
		logic signed [CoordW-1:0] world_y;
		logic signed [CoordW-1:0] world_z;
		logic signed [CoordW-1:0] box_low_x;
		logic signed [CoordW-1:0] box_low_y;
		logic signed [CoordW-1:0] box_low_z;
		logic signed [CoordW-1:0] box_high_x;
		logic signed [CoordW-1:0] box_high_y;
		logic signed [CoordW-1:0] box_high_z;
	} result_t;

	// Horner divisors of the sine series, innermost first
	function automatic logic [7:0] series_div(input logic [2:0] i);
		logic [7:0] d;
		case (i)
			3'd0:    d = 8'd156;
			3'd1:    d = 8'd110;
			3'd2:    d = 8'd72;
			3'd3:    d = 8'd42;
			3'd4:    d = 8'd20;
			default: d = 8'd6;
		endcase
		return d;
	endfunction

	// floor(2^34 / divisor); quotient is then low by at most one
	function automatic logic [31:0] series_recip(input logic [2:0] i);
		logic [31:0] m;
		case (i)
			3'd0:    m = 32'd110127366;
			3'd1:    m = 32'd156180628;
			3'd2:    m = 32'd238609294;
			3'd3:    m = 32'd409044504;
			3'd4:    m = 32'd858993459;
			default: m = 32'd2863311530;
		endcase
		return m;
	endfunction

	// rotation product j: row and column of the matrix term
	function automatic logic [1:0] xf_row(input logic [3:0] j);
		logic [1:0] r;
		priority if (j < 4'd3) r = 2'd0;
		else if (j < 4'd6)     r = 2'd1;
		else                   r = 2'd2;
		return r;
	endfunction

	function automatic logic [1:0] xf_col(input logic [3:0] j);
		logic [3:0] c;
		c = j - 4'd3 * {2'd0, xf_row(j)};
		return c[1:0];
	endfunction

	// product shifted right by s, rounded half away from zero
	function automatic logic signed [ProdW-1:0] round_shift(
		input logic signed [ProdW-1:0] p, input int s);
		logic [ProdW-1:0] mag;
		logic [ProdW-1:0] half;
		mag  = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
		half = ProdW'(1) << (s - 1);
		mag  = (mag + half) >> s;
		return p[ProdW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic coord_t sat_coord(input logic signed [ProdW-1:0] v);
		coord_t r;
		if (v[ProdW-1:CoordW-1] == '0 || v[ProdW-1:CoordW-1] == '1)
			r = v[CoordW-1:0];
		else if (v[ProdW-1])
			r = {1'b1, {(CoordW-1){1'b0}}};
		else
			r = {1'b0, {(CoordW-1){1'b1}}};
		return r;
	endfunction

	function automatic trig_t sat_trig(input logic signed [TrigAccW-1:0] v);
		trig_t r;
		if (v[TrigAccW-1:TrigW-1] == '0 || v[TrigAccW-1:TrigW-1] == '1)
			r = v[TrigW-1:0];
		else if (v[TrigAccW-1])
			r = {1'b1, {(TrigW-1){1'b0}}};
		else
			r = {1'b0, {(TrigW-1){1'b1}}};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/euler_vertex_transform_bounds.sv =====
// ----------------------------------------------------------------------------
// euler_vertex_transform_bounds: scaled ZYX Euler transform with running box
// One 33x33 multiplier under a small sequencer builds the rotation matrix
// from the angle registers and transforms one vertex per item into world
// space, keeping the axis-aligned bounding box of the vertices since the last restart.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | item / access
//  ---------+------------------------------------------+----------------------
//  vertex   | vertex_valid, vertex_stall, vertex       | model vertex + restart
//  result   | result_valid, result_stall, result       | world vertex + box
//  config   | psel penable pwrite paddr pwdata prdata  | 7 regs at 4*index
//
//  An item passes through ST_XFORM: 12 products on the shared multiplier
//  (3 scale, 9 rotation) plus one drain step, then placement in ST_WORLD
//  and box update in ST_DONE. The next item can be taken once result_valid
//  rises. After reset and after each write to a mapped register the matrix
//  is rebuilt: 6 sine series of 21 products and 14 matrix products, during
//  which vertex_stall is high. A pending result does not block intake; a
//  finished item waits in ST_DONE while the previous result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_vertex_transform_bounds (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 vertex_valid,
	output logic                 vertex_stall,
	input  evtb_pkg::vertex_t    vertex,
	output logic                 result_valid,
	input  logic                 result_stall,
	output evtb_pkg::result_t    result
);
	import evtb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SINE   = 6'b000010,
		ST_MATRIX = 6'b000100,
		ST_XFORM  = 6'b001000,
		ST_WORLD  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		SS_ANGLE  = 4'b0001,
		SS_SQUARE = 4'b0010,
		SS_LOOP   = 4'b0100,
		SS_FINAL  = 4'b1000
	} sine_step_t;

	typedef enum logic [2:0] {
		ACT_SET, ACT_ACC, ACT_ADD, ACT_SUB, ACT_CYSP, ACT_SYSP
	} mat_act_t;

	typedef enum logic [2:0] {
		REG_YAW, REG_PITCH, REG_ROLL, REG_SCALE, REG_OFF_X, REG_OFF_Y, REG_OFF_Z,
		REG_NONE
	} reg_idx_t;

	localparam logic [3:0] XfProducts = 4'd12;
	localparam logic [3:0] MatLast    = 4'd13;
	localparam logic [2:0] SineLast   = 3'd5;
	localparam logic [2:0] IterLast   = 3'd5;
	localparam int         SineShift  = 30 - TrigFrac;

	// config registers
	logic [15:0] yaw_q, pitch_q, roll_q, scale_q;
	coord_t      off_q [3];

	// sequencer
	state_t      state_q;
	sine_step_t  sstep_q;
	logic [2:0]  si_q, iter_q;
	logic [1:0]  sub_q;
	logic [3:0]  mi_q, k_q;
	logic        ph_q;

	// sine series working registers
	logic [31:0] x_q, x2_q, n_q;
	logic [29:0] q0_q;
	logic [30:0] h_q;

	// matrix
	trig_t       trig_q [6];   // sy cy sp cp sr cr
	trig_t       rot_q [9];
	trig_t       cysp_q, sysp_q;
	logic signed [TrigAccW-1:0] macc_q;

	// transform
	vertex_t     in_q;
	coord_t      m_q [3];
	logic signed [AccW-1:0] acc_q [3];
	coord_t      w_q [3];
	coord_t      bmin_q [3], bmax_q [3];
	result_t     out_q;
	logic        out_valid_q;

	// shared multiplier
	logic signed [MulW-1:0]  opa, opb;
	logic signed [ProdW-1:0] p_s1;
	logic [3:0]  tag_s1;
	logic        pv_s1;

	logic        cfg_wr, accept, can_out, done_fire;
	reg_idx_t    cfg_idx;

	assign cfg_idx      = reg_idx_t'(paddr[4:2]);
	assign cfg_wr       = psel & penable & pwrite;
	assign pready       = 1'b1;
	assign vertex_stall = (state_q != ST_IDLE) | cfg_wr;
	assign accept       = vertex_valid & ~vertex_stall;
	assign can_out      = ~out_valid_q | ~result_stall;
	assign done_fire    = (state_q == ST_DONE) & can_out & ~cfg_wr;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		unique case (cfg_idx)
			REG_YAW:   prdata = {{16{yaw_q[15]}}, yaw_q};
			REG_PITCH: prdata = {{16{pitch_q[15]}}, pitch_q};
			REG_ROLL:  prdata = {{16{roll_q[15]}}, roll_q};
			REG_SCALE: prdata = {16'd0, scale_q};
			REG_OFF_X: prdata = off_q[0];
			REG_OFF_Y: prdata = off_q[1];
			REG_OFF_Z: prdata = off_q[2];
			default:   prdata = '0;
		endcase
	end

	// angle for the sine being built; odd entries are cosines (+quarter turn)
	logic [15:0] ang_base, ang;
	logic [14:0] t_val;
	always_comb begin
		unique case (si_q[2:1])
			2'd0:    ang_base = yaw_q;
			2'd1:    ang_base = pitch_q;
			default: ang_base = roll_q;
		endcase
		ang   = ang_base + (si_q[0] ? 16'h4000 : 16'h0000);
		t_val = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
	end

	// matrix program: operands, write-back action and target term
	trig_t     mat_a, mat_b;
	mat_act_t  mat_act;
	logic [3:0] mat_dst;
	always_comb begin
		mat_a   = trig_q[1];
		mat_b   = trig_q[3];
		mat_act = ACT_SET;
		mat_dst = 4'd0;
		unique case (mi_q)
			4'd0:  begin mat_a = trig_q[1]; mat_b = trig_q[3]; mat_act = ACT_SET;  mat_dst = 4'd0; end
			4'd1:  begin mat_a = trig_q[1]; mat_b = trig_q[2]; mat_act = ACT_CYSP; end
			4'd2:  begin mat_a = trig_q[0]; mat_b = trig_q[2]; mat_act = ACT_SYSP; end
			4'd3:  begin mat_a = cysp_q;    mat_b = trig_q[4]; mat_act = ACT_ACC;  end
			4'd4:  begin mat_a = trig_q[0]; mat_b = trig_q[5]; mat_act = ACT_SUB;  mat_dst = 4'd1; end
			4'd5:  begin mat_a = cysp_q;    mat_b = trig_q[5]; mat_act = ACT_ACC;  end
			4'd6:  begin mat_a = trig_q[0]; mat_b = trig_q[4]; mat_act = ACT_ADD;  mat_dst = 4'd2; end
			4'd7:  begin mat_a = trig_q[0]; mat_b = trig_q[3]; mat_act = ACT_SET;  mat_dst = 4'd3; end
			4'd8:  begin mat_a = sysp_q;    mat_b = trig_q[4]; mat_act = ACT_ACC;  end
			4'd9:  begin mat_a = trig_q[1]; mat_b = trig_q[5]; mat_act = ACT_ADD;  mat_dst = 4'd4; end
			4'd10: begin mat_a = sysp_q;    mat_b = trig_q[5]; mat_act = ACT_ACC;  end
			4'd11: begin mat_a = trig_q[1]; mat_b = trig_q[4]; mat_act = ACT_SUB;  mat_dst = 4'd5; end
			4'd12: begin mat_a = trig_q[3]; mat_b = trig_q[4]; mat_act = ACT_SET;  mat_dst = 4'd7; end
			4'd13: begin mat_a = trig_q[3]; mat_b = trig_q[5]; mat_act = ACT_SET;  mat_dst = 4'd8; end
			default: ;
		endcase
	end

	// operand select for the shared multiplier
	logic [3:0] xj;
	coord_t     model_k;
	assign xj = k_q - 4'd3;
	always_comb begin
		unique case (k_q[1:0])
			2'd0:    model_k = in_q.model_x;
			2'd1:    model_k = in_q.model_y;
			default: model_k = in_q.model_z;
		endcase
	end

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (state_q)
			ST_SINE: begin
				unique case (sstep_q)
					SS_ANGLE: begin
						opa = MulW'({1'b0, t_val});
						opb = MulW'({1'b0, PiQ30});
					end
					SS_SQUARE: begin
						opa = MulW'({1'b0, x_q});
						opb = MulW'({1'b0, x_q});
					end
					SS_LOOP: begin
						unique case (sub_q)
							2'd0: begin
								opa = MulW'({1'b0, x2_q});
								opb = MulW'({1'b0, h_q});
							end
							2'd1: begin
								opa = MulW'({1'b0, n_q});
								opb = MulW'({1'b0, series_recip(iter_q)});
							end
							default: begin
								opa = MulW'({1'b0, q0_q});
								opb = MulW'({1'b0, series_div(iter_q)});
							end
						endcase
					end
					SS_FINAL: begin
						opa = MulW'({1'b0, x_q});
						opb = MulW'({1'b0, h_q});
					end
					default: ;
				endcase
			end
			ST_MATRIX: begin
				opa = MulW'(mat_a);
				opb = MulW'(mat_b);
			end
			ST_XFORM: begin
				if (k_q < 4'd3) begin
					opa = MulW'(model_k);
					opb = MulW'({1'b0, scale_q});
				end else if (k_q < XfProducts) begin
					opa = MulW'(rot_q[xj]);
					opb = MulW'(m_q[xf_col(xj)]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1   <= opa * opb;
		tag_s1 <= k_q;
	end

	// write-back values
	logic signed [ProdW-1:0]    tr_full, sc_full;
	logic signed [TrigAccW-1:0] tr;
	logic [31:0]  s30, sv, rem;
	logic [29:0]  q_fix;
	logic [3:0]   tj;
	always_comb begin
		tr_full = round_shift(p_s1, TrigFrac);
		sc_full = round_shift(p_s1, ScaleFrac);
		tr      = tr_full[TrigAccW-1:0];
		s30     = p_s1[61:30];
		sv      = (s30 + (32'd1 << (SineShift - 1))) >> SineShift;
		rem     = n_q - p_s1[31:0];
		q_fix   = q0_q + ((rem >= {24'd0, series_div(iter_q)}) ? 30'd1 : 30'd0);
		tj      = tag_s1 - 4'd3;
	end

	// datapath registers (no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= vertex;
		end
		if (state_q == ST_SINE && ph_q) begin
			unique case (sstep_q)
				SS_ANGLE: begin
					x_q <= p_s1[46:15];
					h_q <= OneQ30;
				end
				SS_SQUARE: x2_q <= p_s1[61:30];
				SS_LOOP: begin
					unique case (sub_q)
						2'd0:    n_q  <= p_s1[61:30];
						2'd1:    q0_q <= p_s1[63:34];
						default: h_q  <= OneQ30 - {1'b0, q_fix};
					endcase
				end
				SS_FINAL: trig_q[si_q] <= ang[15] ? -trig_t'(sv) : trig_t'(sv);
				default: ;
			endcase
		end
		if (state_q == ST_MATRIX && ph_q) begin
			unique case (mat_act)
				ACT_SET:  rot_q[mat_dst] <= sat_trig(tr);
				ACT_ACC:  macc_q <= tr;
				ACT_ADD:  rot_q[mat_dst] <= sat_trig(macc_q + tr);
				ACT_SUB:  rot_q[mat_dst] <= sat_trig(macc_q - tr);
				ACT_CYSP: cysp_q <= tr[TrigW-1:0];
				ACT_SYSP: sysp_q <= tr[TrigW-1:0];
				default: ;
			endcase
			if (mi_q == MatLast) begin
				rot_q[6] <= sat_trig(-TrigAccW'(trig_q[2]));
			end
		end
		if (pv_s1) begin
			if (tag_s1 < 4'd3) begin
				m_q[tag_s1[1:0]] <= sat_coord(sc_full);
			end else if (xf_col(tj) == 2'd0) begin
				acc_q[xf_row(tj)] <= tr_full[AccW-1:0];
			end else begin
				acc_q[xf_row(tj)] <= acc_q[xf_row(tj)] + tr_full[AccW-1:0];
			end
		end
		if (state_q == ST_WORLD) begin
			w_q[0] <= sat_coord(ProdW'(MapMid - (AccW'(off_q[0]) + acc_q[0])));
			w_q[1] <= sat_coord(ProdW'(MapMid - (AccW'(off_q[1]) + acc_q[1])));
			w_q[2] <= sat_coord(ProdW'(AccW'(off_q[2]) + acc_q[2]));
		end
	end

	// box update: restart falls back to the empty-box extremes
	coord_t lo_base [3], hi_base [3], lo_new [3], hi_new [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lo_base[i] = in_q.restart_box ? {1'b0, {(CoordW-1){1'b1}}} : bmin_q[i];
			hi_base[i] = in_q.restart_box ? {1'b1, {(CoordW-1){1'b0}}} : bmax_q[i];
			lo_new[i]  = (w_q[i] < lo_base[i]) ? w_q[i] : lo_base[i];
			hi_new[i]  = (w_q[i] > hi_base[i]) ? w_q[i] : hi_base[i];
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q <= '{world_x: w_q[0], world_y: w_q[1], world_z: w_q[2],
				box_low_x: lo_new[0], box_low_y: lo_new[1], box_low_z: lo_new[2],
				box_high_x: hi_new[0], box_high_y: hi_new[1], box_high_z: hi_new[2]};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q       <= '0;
			pitch_q     <= '0;
			roll_q      <= '0;
			scale_q     <= 16'd4096;
			off_q       <= '{default: '0};
			state_q     <= ST_SINE;
			sstep_q     <= SS_ANGLE;
			si_q        <= '0;
			iter_q      <= '0;
			sub_q       <= '0;
			mi_q        <= '0;
			k_q         <= '0;
			ph_q        <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			bmin_q      <= '{default: {1'b0, {(CoordW-1){1'b1}}}};
			bmax_q      <= '{default: {1'b1, {(CoordW-1){1'b0}}}};
		end else begin
			pv_s1 <= (state_q == ST_XFORM) && (k_q < XfProducts);
			// a new result replaces the one taken at this edge
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_YAW:   yaw_q    <= pwdata[15:0];
					REG_PITCH: pitch_q  <= pwdata[15:0];
					REG_ROLL:  roll_q   <= pwdata[15:0];
					REG_SCALE: scale_q  <= pwdata[15:0];
					REG_OFF_X: off_q[0] <= pwdata;
					REG_OFF_Y: off_q[1] <= pwdata;
					REG_OFF_Z: off_q[2] <= pwdata;
					default: ;
				endcase
				if (cfg_idx != REG_NONE) begin
					state_q <= ST_SINE;
					sstep_q <= SS_ANGLE;
					si_q    <= '0;
					ph_q    <= 1'b0;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_XFORM;
							k_q     <= '0;
						end
					end
					ST_SINE: begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							unique case (sstep_q)
								SS_ANGLE:  sstep_q <= SS_SQUARE;
								SS_SQUARE: begin
									sstep_q <= SS_LOOP;
									iter_q  <= '0;
									sub_q   <= '0;
								end
								SS_LOOP: begin
									if (sub_q == 2'd2) begin
										sub_q <= '0;
										if (iter_q == IterLast) sstep_q <= SS_FINAL;
										else iter_q <= iter_q + 3'd1;
									end else begin
										sub_q <= sub_q + 2'd1;
									end
								end
								SS_FINAL: begin
									sstep_q <= SS_ANGLE;
									if (si_q == SineLast) begin
										state_q <= ST_MATRIX;
										mi_q    <= '0;
									end else begin
										si_q <= si_q + 3'd1;
									end
								end
								default: ;
							endcase
						end
					end
					ST_MATRIX: begin
						ph_q <= ~ph_q;
						if (ph_q) begin
							if (mi_q == MatLast) state_q <= ST_IDLE;
							else mi_q <= mi_q + 4'd1;
						end
					end
					ST_XFORM: begin
						if (k_q == XfProducts) state_q <= ST_WORLD;
						else k_q <= k_q + 4'd1;
					end
					ST_WORLD: state_q <= ST_DONE;
					ST_DONE: begin
						if (can_out) begin
							bmin_q      <= lo_new;
							bmax_q      <= hi_new;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a box update");

	a_box_holds_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.box_low_x <= result.world_x)
			&& (result.world_x <= result.box_high_x)
			&& (result.box_low_y <= result.world_y)
			&& (result.world_y <= result.box_high_y)
			&& (result.box_low_z <= result.world_z)
			&& (result.world_z <= result.box_high_z))
		else $error("world vertex outside reported box");

	a_xform_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_XFORM && k_q == XfProducts && !cfg_wr) |=> state_q == ST_WORLD)
		else $error("transform sequence did not drain");

	a_write_rebuilds: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg_idx != REG_NONE) |=> (state_q == ST_SINE && si_q == 3'd0))
		else $error("register write did not restart matrix build");
`endif

endmodule

`default_nettype wire

// ===== sim/euler_vertex_transform_bounds_tb.sv =====
// ----------------------------------------------------------------------------
// euler_vertex_transform_bounds_tb: self-checking bench for the vertex transform
// Drives model vertices through the valid/stall channel in phases, rewrites
// every register over APB between phases (extremes included), predicts world
// vertex and running box per item, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_vertex_transform_bounds_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import evtb_pkg::*;

	typedef enum int {
		REG_YAW = 0, REG_PITCH = 1, REG_ROLL = 2, REG_SCALE = 3,
		REG_OFFSET_X = 4, REG_OFFSET_Y = 5, REG_OFFSET_Z = 6
	} reg_index_e;

	localparam longint CoordMax = 64'sd2147483647;
	localparam longint CoordMin = -64'sd2147483648;
	localparam longint MidQ14   = 64'sd279620267;
	localparam int     CycleLimit = 600000;

	// ------------------------------------------------------------------
	// Scoreboard: own copy of registers, matrix and box; queue of expected
	// world items in acceptance order.
	// ------------------------------------------------------------------
	class vertex_scoreboard;
		int unsigned angle[3];
		int unsigned scale;
		longint      offset[3];
		longint      box_lo[3];
		longint      box_hi[3];
		longint      rot[9];
		result_t     pending_world[$];
		int          fails;

		function new();
			fails = 0;
			angle = '{0, 0, 0};
			scale = 4096;
			offset = '{0, 0, 0};
			clear_box();
			build_matrix();
		endfunction

		task report(string what);
			fails++;
			$display("mismatch: %s", what);
		endtask

		function void clear_box();
			for (int i = 0; i < 3; i++) begin
				box_lo[i] = CoordMax;
				box_hi[i] = CoordMin;
			end
		endfunction

		function longint clamp(longint v, int w);
			longint hi, lo;
			hi = (64'sd1 <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		// a*b >> s, rounded half away from zero
		function longint mul_rnd(longint a, longint b, int s);
			logic signed [127:0] p;
			logic [127:0] m;
			longint r;
			p = 128'(a) * 128'(b);
			m = p[127] ? -p : p;
			m = (m + (128'd1 << (s - 1))) >> s;
			r = longint'(m[63:0]);
			return p[127] ? -r : r;
		endfunction

		// Horner series sine on a quarter turn, Q30 then rounded to Q16
		function longint quarter_sine(int unsigned t);
			logic [63:0] x, x2, h, s30;
			logic [63:0] dv[6];
			dv = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
			x  = (64'(t) * 64'd3373259426) >> 15;
			x2 = (x * x) >> 30;
			h  = 64'd1 << 30;
			for (int i = 0; i < 6; i++)
				h = (64'd1 << 30) - ((x2 * h) >> 30) / dv[i];
			s30 = (x * h) >> 30;
			return longint'((s30 + (64'd1 << 13)) >> 14);
		endfunction

		function longint turn_sine(int unsigned a);
			int unsigned q, r;
			longint v;
			q = (a >> 14) & 3;
			r = a & 16'h3FFF;
			v = (q & 1) ? quarter_sine(16384 - r) : quarter_sine(r);
			return (q & 2) ? -v : v;
		endfunction

		function longint tm(longint a, longint b);
			return mul_rnd(a, b, TrigFrac);
		endfunction

		// Rz(yaw) * Ry(pitch) * Rx(roll)
		function void build_matrix();
			longint sy, cy, sp, cp, sr, cr, cysp, sysp;
			longint m[9];
			sy = turn_sine(angle[0]); cy = turn_sine(angle[0] + 16384);
			sp = turn_sine(angle[1]); cp = turn_sine(angle[1] + 16384);
			sr = turn_sine(angle[2]); cr = turn_sine(angle[2] + 16384);
			cysp = tm(cy, sp);
			sysp = tm(sy, sp);
			m[0] = tm(cy, cp);
			m[1] = tm(cysp, sr) - tm(sy, cr);
			m[2] = tm(cysp, cr) + tm(sy, sr);
			m[3] = tm(sy, cp);
			m[4] = tm(sysp, sr) + tm(cy, cr);
			m[5] = tm(sysp, cr) - tm(cy, sr);
			m[6] = -sp;
			m[7] = tm(cp, sr);
			m[8] = tm(cp, cr);
			for (int i = 0; i < 9; i++)
				rot[i] = clamp(m[i], TrigW);
		endfunction

		function void write_reg(reg_index_e idx, logic [31:0] val);
			case (idx)
				REG_YAW:      angle[0] = val[15:0];
				REG_PITCH:    angle[1] = val[15:0];
				REG_ROLL:     angle[2] = val[15:0];
				REG_SCALE:    scale = val[15:0];
				REG_OFFSET_X: offset[0] = longint'($signed(val));
				REG_OFFSET_Y: offset[1] = longint'($signed(val));
				REG_OFFSET_Z: offset[2] = longint'($signed(val));
				default: ;
			endcase
			build_matrix();
		endfunction

		function void note_vertex(vertex_t v);
			longint sc[3], r[3], w[3];
			result_t e;
			sc[0] = clamp(mul_rnd(longint'(v.model_x), scale, ScaleFrac), CoordW);
			sc[1] = clamp(mul_rnd(longint'(v.model_y), scale, ScaleFrac), CoordW);
			sc[2] = clamp(mul_rnd(longint'(v.model_z), scale, ScaleFrac), CoordW);
			for (int i = 0; i < 3; i++)
				r[i] = mul_rnd(rot[3*i], sc[0], TrigFrac)
				     + mul_rnd(rot[3*i+1], sc[1], TrigFrac)
				     + mul_rnd(rot[3*i+2], sc[2], TrigFrac);
			w[0] = clamp(MidQ14 - (offset[0] + r[0]), CoordW);
			w[1] = clamp(MidQ14 - (offset[1] + r[1]), CoordW);
			w[2] = clamp(offset[2] + r[2], CoordW);
			if (v.restart_box)
				clear_box();
			for (int i = 0; i < 3; i++) begin
				if (w[i] < box_lo[i]) box_lo[i] = w[i];
				if (w[i] > box_hi[i]) box_hi[i] = w[i];
			end
			e.world_x = w[0][31:0];      e.world_y = w[1][31:0];      e.world_z = w[2][31:0];
			e.box_low_x = box_lo[0][31:0]; e.box_low_y = box_lo[1][31:0];
			e.box_low_z = box_lo[2][31:0];
			e.box_high_x = box_hi[0][31:0]; e.box_high_y = box_hi[1][31:0];
			e.box_high_z = box_hi[2][31:0];
			pending_world = {pending_world, e};
		endfunction

		task check_result(result_t got);
			string names[9];
			result_t e;
			logic [31:0] g, x;
			names = '{"world_x", "world_y", "world_z", "box_low_x", "box_low_y",
				"box_low_z", "box_high_x", "box_high_y", "box_high_z"};
			if (pending_world.size() == 0) begin
				report("result item with nothing expected");
				return;
			end
			e = pending_world[0];
			pending_world.delete(0);
			for (int i = 0; i < 9; i++) begin
				g = got[(8 - i) * 32 +: 32];
				x = e[(8 - i) * 32 +: 32];
				if (g !== x)
					report($sformatf("%s got %h want %h", names[i], g, x));
			end
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT and stimulus signals; the stimulus is known from time zero
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        vertex_valid = 1'b0;
	logic        vertex_stall;
	vertex_t     vertex = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;

	bit          calm = 1'b0;   // no idling on either side while set
	int          cycles = 0;
	vertex_scoreboard sb = new();

	always #1 clk = ~clk;

	euler_vertex_transform_bounds dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.vertex_valid, .vertex_stall, .vertex, .result_valid, .result_stall, .result
	);

	// Result side: check accepted items, stall about 35% of cycles unless calm is set.
	// Values read here are the ones before this edge's updates.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			if (arst_n && result_valid && !result_stall)
				sb.check_result(result);
			result_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
		end
	end

	// One item on the vertex channel; returns at the accepting edge.
	// Valid only drops ahead of a gap, so it never toggles within a step.
	task automatic send_vertex(vertex_t v);
		if (!calm && $urandom_range(99) < 35) begin
			vertex_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		vertex <= v;
		vertex_valid <= 1'b1;
		@(posedge clk);
		while (vertex_stall) @(posedge clk);
		sb.note_vertex(v);
	endtask

	task automatic end_burst();
		vertex_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_world.size() != 0) @(posedge clk);
	endtask

	// APB write: setup then access; register lands on the access edge,
	// then the bus idles before the next transfer
	task automatic write_reg(reg_index_e idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(4))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
			3: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
			default: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		logic [15:0] set[5];
		set = '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000};
		return ($urandom_range(3) == 0) ? set[$urandom_range(4)] : 16'($urandom);
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		v.model_x = pick_coord();
		v.model_y = pick_coord();
		v.model_z = pick_coord();
		v.restart_box = ($urandom_range(7) == 0);
		return v;
	endfunction

	initial begin
		vertex_t v;
		logic [15:0] sc;
		logic [31:0] dir[8];
		dir = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
			32'h0000_4000, 32'hFFFF_C000, 32'h0010_0000, 32'hFFF0_0000};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: field extremes, both restart values,
		// mixed signs; the matrix rebuild after reset shows up as stall.
		for (int i = 0; i < 8; i++) begin
			v.model_x = dir[i];
			v.model_y = dir[(i + 3) % 8];
			v.model_z = dir[(i + 5) % 8];
			v.restart_box = i[0];
			send_vertex(v);
		end
		for (int i = 0; i < 8; i++) begin
			v.model_x = dir[i]; v.model_y = dir[i]; v.model_z = dir[i];
			v.restart_box = (i == 4);
			send_vertex(v);
		end
		end_burst();

		// Phases: first two pin the extremes (incl. zero scale), the rest
		// are random. Phase 4 runs without idling on either side.
		for (int p = 1; p <= 8; p++) begin
			case (p)
				1: begin
					write_reg(REG_YAW, 32'h0000_7FFF);
					write_reg(REG_PITCH, 32'hFFFF_8000);
					write_reg(REG_ROLL, 32'h0000_4000);
					write_reg(REG_SCALE, 32'h0000_FFFF);
					write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
					write_reg(REG_OFFSET_Y, 32'h7FFF_FFFF);
					write_reg(REG_OFFSET_Z, 32'h8000_0000);
				end
				2: begin
					write_reg(REG_YAW, 32'h0);
					write_reg(REG_PITCH, 32'h0);
					write_reg(REG_ROLL, 32'h0);
					write_reg(REG_SCALE, 32'h0);
					write_reg(REG_OFFSET_X, 32'h8000_0000);
					write_reg(REG_OFFSET_Y, 32'h8000_0000);
					write_reg(REG_OFFSET_Z, 32'h7FFF_FFFF);
				end
				default: begin
					write_reg(REG_YAW, {16'($urandom), pick_angle()});
					write_reg(REG_PITCH, {16'($urandom), pick_angle()});
					write_reg(REG_ROLL, {16'($urandom), pick_angle()});
					case ($urandom_range(3))
						0: sc = 16'h1000;
						1: sc = 16'($urandom_range(0, 16'h2000));
						default: sc = 16'($urandom);
					endcase
					write_reg(REG_SCALE, {16'($urandom), sc});
					write_reg(REG_OFFSET_X, ($urandom_range(1)) ? pick_coord() : 32'h0);
					write_reg(REG_OFFSET_Y, pick_coord());
					write_reg(REG_OFFSET_Z, pick_coord());
				end
			endcase
			calm = (p == 4);
			for (int i = 0; i < 205; i++)
				send_vertex(rand_vertex());
			end_burst();
			calm = 1'b0;
		end

		// let any stray late result show up
		repeat (60) @(posedge clk);
		if (sb.fails == 0 && sb.pending_world.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/evtb_pkg.sv
design/euler_vertex_transform_bounds.sv
sim/euler_vertex_transform_bounds_tb.sv
